FILE: design/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sobel_pkg.sv
// Shared constants, types and functions of the Sobel edge block
`default_nettype none
package sobel_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAME_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(FRAME_SIZE);

  localparam int DIM_W  = 10;
  localparam int SEL_W  = 9;
  localparam int PIX_W  = 8;
  localparam int THR_W  = 10;
  localparam int MODE_W = 3;
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 3;
  localparam int POS_W  = DIM_W + 2;
  localparam int PROD_W = 2 * DIM_W;
  localparam int CMP_W  = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;
  localparam int ACC_W  = 12;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd2;
  localparam logic [IDX_W-1:0] REG_BORDER_MODE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_BORDER_VALUE   = 3'd4;

  localparam logic [MODE_W-1:0] PAD_CLAMP     = 3'd0;
  localparam logic [MODE_W-1:0] PAD_MIRROR    = 3'd1;
  localparam logic [MODE_W-1:0] PAD_MIRROR101 = 3'd2;
  localparam logic [MODE_W-1:0] PAD_CYCLIC    = 3'd3;
  localparam logic [MODE_W-1:0] PAD_FILL      = 3'd4;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic       load;
    logic       accept_compute;
    logic       issue;
    logic [1:0] tap_m;
    logic [1:0] tap_n;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_outside;
    logic acc_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             is_const;
    logic [DIM_W-1:0] idx;
  } map_t;

  function automatic map_t map_index(logic signed [POS_W-1:0] pos,
                                     logic [DIM_W-1:0] len,
                                     logic [MODE_W-1:0] mode);
    map_t res;
    logic lo;
    logic hi;
    logic one;
    lo = pos < 0;
    hi = pos >= $signed({2'b00, len});
    one = len == DIM_W'(1);
    res.is_const = 1'b0;
    res.idx = pos[DIM_W-1:0];
    if (lo) begin
      case (mode)
        PAD_MIRROR:    res.idx = '0;
        PAD_MIRROR101: res.idx = one ? DIM_W'(0) : DIM_W'(1);
        PAD_CYCLIC:    res.idx = len - DIM_W'(1);
        PAD_FILL:      res.is_const = 1'b1;
        default:       res.idx = '0;
      endcase
    end else if (hi) begin
      case (mode)
        PAD_MIRROR:    res.idx = len - DIM_W'(1);
        PAD_MIRROR101: res.idx = one ? DIM_W'(0) : len - DIM_W'(2);
        PAD_CYCLIC:    res.idx = '0;
        PAD_FILL:      res.is_const = 1'b1;
        default:       res.idx = len - DIM_W'(1);
      endcase
    end
    return res;
  endfunction

  function automatic logic signed [2:0] kern_x(logic [1:0] m, logic [1:0] n);
    logic signed [2:0] mag;
    mag = (m == 2'd1) ? 3'sd2 : 3'sd1;
    case (n)
      2'd0:    return -mag;
      2'd2:    return mag;
      default: return 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] kern_y(logic [1:0] m, logic [1:0] n);
    logic signed [2:0] mag;
    mag = (n == 2'd1) ? 3'sd2 : 3'sd1;
    case (m)
      2'd0:    return mag;
      2'd2:    return -mag;
      default: return 3'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/sobel_edge_threshold.sv
// Top level of the Sobel 3x3 edge detector with threshold
//
//   channel  direction  handshake                 payload
//   input    in         in_valid / in_stall       func, pixel_in, row_sel, col_sel
//   result   out        out_valid / out_stall     edge_out
//   config   in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load writes the frame memory in the cycle of its transfer.
// A compute inside the frame runs the transfer, nine reads of the single-port frame memory,
// one per cycle, a pipeline drain and the registering of the result.
// A compute outside the frame skips the reads and gives 0.
// Synchronous reset clears control and sets the configuration to its defaults; the frame memory is not cleared.
// A held result holds the next compute, and the input with it, at its result cycle.
`default_nettype none
`include "assert_macros.svh"
module sobel_edge_threshold import sobel_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             func,
  input  wire logic [PIX_W-1:0] pixel_in,
  input  wire logic [SEL_W-1:0] row_sel,
  input  wire logic [SEL_W-1:0] col_sel,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [PIX_W-1:0] edge_out,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sobel_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .row_sel   (row_sel),
    .col_sel   (col_sel),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .edge_out  (edge_out)
  );

  `CHK_SAME(a_out_load_free, cmd.out_load, !out_valid || !out_stall, "held result overwritten")
  `CHK_NEXT(a_compute_busy, cmd.accept_compute && !status.req_outside, in_stall, "idle in compute")
  `CHK_SAME(a_acc_while_busy, status.acc_last, in_stall, "accumulation finished while idle")

endmodule
`default_nettype wire

FILE: design/sobel_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: design/sobel_ctrl.sv
// Controller: item acceptance and tap sequencing
`default_nettype none
module sobel_ctrl import sobel_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       func,
  input  wire dp_status_t status,
  output logic            in_stall,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] tap_m;
  logic [1:0] tap_m_next;
  logic [1:0] tap_n;
  logic [1:0] tap_n_next;
  logic       accept;

  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    cmd.load           = accept && (func == FUNC_LOAD);
    cmd.accept_compute = accept && (func == FUNC_COMPUTE);
    cmd.issue          = state == ST_RUN;
    cmd.tap_m          = tap_m;
    cmd.tap_n          = tap_n;
    cmd.out_load       = (state == ST_DONE) && status.out_free;
  end

  always_comb begin
    state_next = state;
    tap_m_next = tap_m;
    tap_n_next = tap_n;
    case (state)
      ST_IDLE: begin
        if (cmd.accept_compute) begin
          tap_m_next = '0;
          tap_n_next = '0;
          state_next = status.req_outside ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_n == 2'd2) begin
          tap_n_next = '0;
          if (tap_m == 2'd2) begin
            state_next = ST_DRAIN;
          end else begin
            tap_m_next = tap_m + 2'd1;
          end
        end else begin
          tap_n_next = tap_n + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (status.acc_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap_m <= '0;
      tap_n <= '0;
    end else begin
      state <= state_next;
      tap_m <= tap_m_next;
      tap_n <= tap_n_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/sobel_dp.sv
// Datapath: configuration, frame store, border mapping and Sobel sums
`default_nettype none
module sobel_dp import sobel_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [PIX_W-1:0]  pixel_in,
  input  wire logic [SEL_W-1:0]  row_sel,
  input  wire logic [SEL_W-1:0]  col_sel,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic              out_stall,
  output dp_status_t             status,
  output logic                   out_valid,
  output logic      [PIX_W-1:0]  edge_out
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [THR_W-1:0]  edge_threshold;
  logic [MODE_W-1:0] border_mode;
  logic [PIX_W-1:0]  border_value;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [PROD_W-1:0] total;

  logic [ADDR_W-1:0] load_pointer;
  logic [ADDR_W-1:0] load_pointer_next;
  logic [ADDR_W-1:0] load_addr;
  logic [CMP_W-1:0]  load_inc;

  logic [SEL_W-1:0]  req_row;
  logic [SEL_W-1:0]  req_col;
  logic              forced_zero;

  logic signed [POS_W-1:0] row_pos;
  logic signed [POS_W-1:0] col_pos;
  map_t              row_map;
  map_t              col_map;

  logic              s1_valid;
  logic [1:0]        s1_m;
  logic [1:0]        s1_n;
  logic [DIM_W-1:0]  s1_row;
  logic [DIM_W-1:0]  s1_col;
  logic              s1_const;
  logic              s2_valid;
  logic [1:0]        s2_m;
  logic [1:0]        s2_n;
  logic              s2_const;

  logic [PROD_W-1:0] tap_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  logic [PIX_W-1:0]        pix;
  logic signed [ACC_W-1:0] pix_s;
  logic signed [ACC_W-1:0] term_x;
  logic signed [ACC_W-1:0] term_y;
  logic signed [ACC_W-1:0] sum_x;
  logic signed [ACC_W-1:0] sum_y;
  logic signed [ACC_W-1:0] abs_x;
  logic signed [ACC_W-1:0] abs_y;
  logic signed [ACC_W-1:0] mag;
  logic                    is_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(512);
      image_height   <= DIM_W'(512);
      edge_threshold <= THR_W'(128);
      border_mode    <= PAD_CLAMP;
      border_value   <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
        REG_BORDER_MODE:    border_mode    <= cfg_data[MODE_W-1:0];
        REG_BORDER_VALUE:   border_value   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame dimensions to the store, and a zero dimension to 1
  always_comb begin
    if (image_width == '0) begin
      w = DIM_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = DIM_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  assign total = PROD_W'(w) * PROD_W'(h);

  always_comb begin
    load_addr = (CMP_W'(load_pointer) >= CMP_W'(total)) ? '0 : load_pointer;
    load_inc  = CMP_W'(load_addr) + CMP_W'(1);
    load_pointer_next = (load_inc >= CMP_W'(total)) ? '0 : load_inc[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
    end else if (cmd.load) begin
      load_pointer <= load_pointer_next;
    end
  end

  assign status.req_outside = (DIM_W'(row_sel) >= h) || (DIM_W'(col_sel) >= w);

  always_ff @(posedge clk) begin
    if (cmd.accept_compute) begin
      req_row <= row_sel;
      req_col <= col_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_zero <= 1'b0;
    end else if (cmd.accept_compute) begin
      forced_zero <= status.req_outside;
    end
  end

  // map the neighbour position into the frame
  always_comb begin
    row_pos = $signed(POS_W'(req_row)) + $signed(POS_W'(cmd.tap_m)) - POS_W'(1);
    col_pos = $signed(POS_W'(req_col)) + $signed(POS_W'(cmd.tap_n)) - POS_W'(1);
    row_map = map_index(row_pos, h, border_mode);
    col_map = map_index(col_pos, w, border_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_m     <= cmd.tap_m;
    s1_n     <= cmd.tap_n;
    s1_row   <= row_map.idx;
    s1_col   <= col_map.idx;
    s1_const <= row_map.is_const || col_map.is_const;
    s2_m     <= s1_m;
    s2_n     <= s1_n;
    s2_const <= s1_const;
  end

  assign tap_addr = PROD_W'(s1_row) * PROD_W'(w) + PROD_W'(s1_col);
  assign ram_addr = cmd.load ? load_addr : ADDR_W'(tap_addr);

  sobel_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_SIZE)
  ) u_frame (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (ram_addr),
    .wdata (pixel_in),
    .rdata (ram_rdata)
  );

  always_comb begin
    pix    = s2_const ? border_value : ram_rdata;
    pix_s  = $signed(ACC_W'(pix));
    term_x = pix_s * ACC_W'(kern_x(s2_m, s2_n));
    term_y = pix_s * ACC_W'(kern_y(s2_m, s2_n));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_compute) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (s2_valid) begin
      sum_x <= sum_x + term_x;
      sum_y <= sum_y + term_y;
    end
  end

  assign status.acc_last = s2_valid && (s2_m == 2'd2) && (s2_n == 2'd2);

  always_comb begin
    abs_x   = (sum_x < 0) ? -sum_x : sum_x;
    abs_y   = (sum_y < 0) ? -sum_y : sum_y;
    mag     = (abs_x > abs_y) ? abs_x : abs_y;
    is_edge = !forced_zero && ($unsigned(mag) > ACC_W'(edge_threshold));
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      edge_out <= is_edge ? EDGE_ON : EDGE_OFF;
    end
  end

endmodule
`default_nettype wire
